// ----- rtl/ttlsf_pkg.sv -----
package ttlsf_pkg;

   // Field and datapath widths.
   localparam int IN_W     = 16;
   localparam int SUM_W    = 48;
   localparam int PROD_W   = 2 * SUM_W;
   localparam int ACC_W    = PROD_W + 2;
   localparam int OUT_FRAC = 16;
   localparam int NUM_W    = PROD_W + OUT_FRAC;
   localparam int COEF_W   = 32;
   localparam int CHUNK_W  = 16;

   // Default depth of the queue between the accumulator and the solver.
   localparam int QUEUE_DEPTH_DEF = 2;

   // Saturation limits of a Q16.16 coefficient.
   localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

   // The five product sums of one data set.
   typedef struct packed {
      logic [SUM_W-1:0] by;
      logic [SUM_W-1:0] ay;
      logic [SUM_W-1:0] bb;
      logic [SUM_W-1:0] ab;
      logic [SUM_W-1:0] aa;
   } sums_type;

   // Solver sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_COMMIT,
      S_DET,
      S_DIV_SETUP,
      S_DIV_CHECK,
      S_DIV_STEP,
      S_DIV_DONE,
      S_OUT
   } state_type;

endpackage

// ----- rtl/two_term_least_squares_fit.sv -----
// Channel   Direction  Handshake            Word
// req_      in         req_valid/req_stall  reg_a, reg_b, response, last
// rsp_      out        rsp_valid/rsp_stall  coef_a, coef_b, singular, saturated
//
// A sample word is accumulated in the cycle it is taken, one per cycle while req_stall is low.
// A word with last set queues its sums; the solver then computes the six cross
// products of a data set on the shared 48x16 multiplier and each of its two
// quotients in the one-bit-per-cycle divider.
// Reset is synchronous and clears the sums, the queue and the solver.
// req_stall rises while the queue of finished sets is full; rsp_stall holds
// the result register, and the solver waits for it only when it has a new one.
module two_term_least_squares_fit #(
   parameter int QUEUE_DEPTH = ttlsf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_reg_a,
   input  logic signed [15:0]  req_reg_b,
   input  logic signed [15:0]  req_response,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_coef_a,
   output logic signed [31:0]  rsp_coef_b,
   output logic                rsp_singular,
   output logic                rsp_saturated
);
   import ttlsf_pkg::*;

   sums_type push_data, head_data;
   logic     push, queue_full, head_valid, pop;

   // Sample accumulator.
   ttlsf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_reg_a    (req_reg_a),
      .req_reg_b    (req_reg_b),
      .req_response (req_response),
      .req_last     (req_last),
      .queue_full   (queue_full),
      .push         (push),
      .push_data    (push_data)
   );

   // Queue of finished sets.
   ttlsf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   // Normal equation solver.
   ttlsf_solve u_solve (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_data     (head_data),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_coef_a    (rsp_coef_a),
      .rsp_coef_b    (rsp_coef_b),
      .rsp_singular  (rsp_singular),
      .rsp_saturated (rsp_saturated)
   );

endmodule

// ----- rtl/ttlsf_front.sv -----
module ttlsf_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [15:0]          req_reg_a,
   input  logic signed [15:0]          req_reg_b,
   input  logic signed [15:0]          req_response,
   input  logic                        req_last,
   input  logic                        queue_full,
   output logic                        push,
   output ttlsf_pkg::sums_type         push_data
);
   import ttlsf_pkg::*;

   sums_type sums_ff, sums_in, sums_next;
   logic signed [2*IN_W-1:0] p_aa, p_ab, p_bb, p_ay, p_by;
   logic accept;

   // A word is taken whenever the queue has room for a finished set.
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Five sample products, one lane each.
   assign p_aa = (2*IN_W)'(req_reg_a) * (2*IN_W)'(req_reg_a);
   assign p_ab = (2*IN_W)'(req_reg_a) * (2*IN_W)'(req_reg_b);
   assign p_bb = (2*IN_W)'(req_reg_b) * (2*IN_W)'(req_reg_b);
   assign p_ay = (2*IN_W)'(req_reg_a) * (2*IN_W)'(req_response);
   assign p_by = (2*IN_W)'(req_reg_b) * (2*IN_W)'(req_response);

   // Running sums including the current sample.
   always_comb begin
      sums_next.aa = sums_ff.aa + SUM_W'(p_aa);
      sums_next.ab = sums_ff.ab + SUM_W'(p_ab);
      sums_next.bb = sums_ff.bb + SUM_W'(p_bb);
      sums_next.ay = sums_ff.ay + SUM_W'(p_ay);
      sums_next.by = sums_ff.by + SUM_W'(p_by);
   end

   // The last sample hands the completed sums to the queue and starts over.
   always_comb begin
      sums_in   = sums_ff;
      push      = 1'b0;
      push_data = sums_next;
      if (accept) begin
         if (req_last) begin
            push    = 1'b1;
            sums_in = '0;
         end else begin
            sums_in = sums_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff <= '0;
      end else begin
         sums_ff <= sums_in;
      end
   end

endmodule

// ----- rtl/ttlsf_queue.sv -----
module ttlsf_queue #(
   parameter int DEPTH = ttlsf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ttlsf_pkg::sums_type   push_data,
   output logic                  full,
   output logic                  head_valid,
   output ttlsf_pkg::sums_type   head_data,
   input  logic                  pop
);
   import ttlsf_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   sums_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates; pointers wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/ttlsf_solve.sv -----
module ttlsf_solve (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  ttlsf_pkg::sums_type   head_data,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [31:0]    rsp_coef_a,
   output logic signed [31:0]    rsp_coef_b,
   output logic                  rsp_singular,
   output logic                  rsp_saturated
);
   import ttlsf_pkg::*;

   // Sum positions in the operand array.
   localparam logic [2:0] IX_AA = 3'd0;
   localparam logic [2:0] IX_AB = 3'd1;
   localparam logic [2:0] IX_BB = 3'd2;
   localparam logic [2:0] IX_AY = 3'd3;
   localparam logic [2:0] IX_BY = 3'd4;
   localparam logic [2:0] LAST_PROD = 3'd5;
   localparam logic [1:0] LAST_CHUNK = 2'd2;
   localparam logic [4:0] LAST_BIT = 5'd31;

   // Operand pairs of the six cross products, in pairs of (plus, minus):
   // det, numerator of coef_a, numerator of coef_b.
   localparam logic [5:0][2:0] OP_X = {IX_AB, IX_AA, IX_AB, IX_BB, IX_AB, IX_AA};
   localparam logic [5:0][2:0] OP_Y = {IX_AY, IX_BY, IX_BY, IX_AY, IX_AB, IX_BB};

   function automatic logic [ACC_W-1:0] abs_acc(input logic [ACC_W-1:0] v);
      abs_acc = v[ACC_W-1] ? (~v + 1'b1) : v;
   endfunction

   state_type                  state_ff, state_in;
   logic [4:0][SUM_W-1:0]      mag_ff, mag_in;
   logic [4:0]                 neg_ff, neg_in;
   logic [4:0][SUM_W-1:0]      head_arr;
   logic [2:0]                 prod_ff, prod_in;
   logic [1:0]                 chunk_ff, chunk_in;
   logic [PROD_W-1:0]          pmag_ff, pmag_in;
   logic [2:0][ACC_W-1:0]      acc_ff, acc_in;
   logic [PROD_W-1:0]          dmag_ff, dmag_in;
   logic                       dneg_ff, dneg_in;
   logic [NUM_W-1:0]           num_ff, num_in;
   logic                       qneg_ff, qneg_in;
   logic [PROD_W:0]            rem_ff, rem_in;
   logic [COEF_W-1:0]          q_ff, q_in;
   logic                       ovf_ff, ovf_in;
   logic [4:0]                 bit_ff, bit_in;
   logic                       quo_ff, quo_in;
   logic [1:0][COEF_W-1:0]     coef_ff, coef_in;
   logic                       sat_ff, sat_in;
   logic                       sing_ff, sing_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0][COEF_W-1:0]     rsp_coef_ff, rsp_coef_in;
   logic                       rsp_sing_ff, rsp_sing_in;
   logic                       rsp_sat_ff, rsp_sat_in;

   logic [SUM_W-1:0]           mag_x, mag_y;
   logic [CHUNK_W-1:0]         y_chunk;
   logic [SUM_W+CHUNK_W-1:0]   pp;
   logic [PROD_W-1:0]          pp_shift;
   logic [ACC_W-1:0]           term, acc_sel, det_abs, num_sel, num_abs;
   logic                       term_neg;
   logic [PROD_W:0]            shifted, dmag_ext;
   logic                       ge;

   assign head_arr = {head_data.by, head_data.ay, head_data.bb, head_data.ab, head_data.aa};

   // Shared 48x16 multiplier: one chunk of the second operand per cycle.
   assign mag_x = mag_ff[OP_X[prod_ff]];
   assign mag_y = mag_ff[OP_Y[prod_ff]];

   always_comb begin
      unique case (chunk_ff)
         2'd0: y_chunk = mag_y[CHUNK_W-1:0];
         2'd1: y_chunk = mag_y[2*CHUNK_W-1:CHUNK_W];
         default: y_chunk = mag_y[3*CHUNK_W-1:2*CHUNK_W];
      endcase
   end

   assign pp = (SUM_W+CHUNK_W)'(mag_x) * (SUM_W+CHUNK_W)'(y_chunk);

   always_comb begin
      unique case (chunk_ff)
         2'd0: pp_shift = PROD_W'(pp);
         2'd1: pp_shift = PROD_W'({pp, {CHUNK_W{1'b0}}});
         default: pp_shift = {pp, {(2*CHUNK_W){1'b0}}};
      endcase
   end

   // Signed contribution of a finished product to its accumulator.
   assign term     = {2'b00, pmag_ff};
   assign term_neg = neg_ff[OP_X[prod_ff]] ^ neg_ff[OP_Y[prod_ff]] ^ prod_ff[0];
   assign acc_sel  = acc_ff[prod_ff[2:1]];

   assign det_abs = abs_acc(acc_ff[0]);
   assign num_sel = quo_ff ? acc_ff[2] : acc_ff[1];
   assign num_abs = abs_acc(num_sel);

   // One restoring division step.
   assign dmag_ext = {1'b0, dmag_ff};
   assign shifted  = {rem_ff[PROD_W-1:0], num_ff[COEF_W-1]};
   assign ge       = (shifted >= dmag_ext);

   // Sequencer: load, six products, determinant, two quotients (skipped when singular), deliver.
   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      chunk_in     = chunk_ff;
      pmag_in      = pmag_ff;
      acc_in       = acc_ff;
      dmag_in      = dmag_ff;
      dneg_in      = dneg_ff;
      num_in       = num_ff;
      qneg_in      = qneg_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      ovf_in       = ovf_ff;
      bit_in       = bit_ff;
      quo_in       = quo_ff;
      coef_in      = coef_ff;
      sat_in       = sat_ff;
      sing_in      = sing_ff;
      pop          = 1'b0;
      rsp_coef_in  = rsp_coef_ff;
      rsp_sing_in  = rsp_sing_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               for (int i = 0; i < 5; i++) begin
                  neg_in[i] = head_arr[i][SUM_W-1];
                  mag_in[i] = head_arr[i][SUM_W-1] ? (~head_arr[i] + 1'b1) : head_arr[i];
               end
               prod_in  = '0;
               chunk_in = '0;
               pmag_in  = '0;
               acc_in   = '0;
               sat_in   = 1'b0;
               sing_in  = 1'b0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            pmag_in = pmag_ff + pp_shift;
            if (chunk_ff == LAST_CHUNK) begin
               state_in = S_COMMIT;
            end else begin
               chunk_in = chunk_ff + 1'b1;
            end
         end
         S_COMMIT: begin
            acc_in[prod_ff[2:1]] = term_neg ? (acc_sel - term) : (acc_sel + term);
            pmag_in  = '0;
            chunk_in = '0;
            if (prod_ff == LAST_PROD) begin
               state_in = S_DET;
            end else begin
               prod_in  = prod_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_DET: begin
            if (acc_ff[0] == '0) begin
               sing_in  = 1'b1;
               coef_in  = '0;
               state_in = S_OUT;
            end else begin
               dneg_in  = acc_ff[0][ACC_W-1];
               dmag_in  = det_abs[PROD_W-1:0];
               quo_in   = 1'b0;
               state_in = S_DIV_SETUP;
            end
         end
         S_DIV_SETUP: begin
            qneg_in  = num_sel[ACC_W-1] ^ dneg_ff;
            num_in   = {num_abs[PROD_W-1:0], {OUT_FRAC{1'b0}}};
            state_in = S_DIV_CHECK;
         end
         S_DIV_CHECK: begin
            // A quotient of 2^32 or more saturates without further steps.
            ovf_in   = (PROD_W'(num_ff[NUM_W-1:COEF_W]) >= dmag_ff);
            rem_in   = (PROD_W+1)'(num_ff[NUM_W-1:COEF_W]);
            q_in     = '0;
            bit_in   = '0;
            state_in = ovf_in ? S_DIV_DONE : S_DIV_STEP;
         end
         S_DIV_STEP: begin
            rem_in = ge ? (shifted - dmag_ext) : shifted;
            q_in   = {q_ff[COEF_W-2:0], ge};
            num_in = {num_ff[NUM_W-2:0], 1'b0};
            bit_in = bit_ff + 1'b1;
            if (bit_ff == LAST_BIT) begin
               state_in = S_DIV_DONE;
            end
         end
         S_DIV_DONE: begin
            // Apply the sign and clip to the Q16.16 range.
            if (!qneg_ff) begin
               if (ovf_ff || q_ff[COEF_W-1]) begin
                  coef_in[quo_ff] = COEF_MAX;
                  sat_in          = 1'b1;
               end else begin
                  coef_in[quo_ff] = q_ff;
               end
            end else begin
               if (ovf_ff || (q_ff > COEF_MIN)) begin
                  coef_in[quo_ff] = COEF_MIN;
                  sat_in          = 1'b1;
               end else begin
                  coef_in[quo_ff] = ~q_ff + 1'b1;
               end
            end
            if (quo_ff) begin
               state_in = S_OUT;
            end else begin
               quo_in   = 1'b1;
               state_in = S_DIV_SETUP;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_coef_in  = coef_ff;
               rsp_sing_in  = sing_ff;
               rsp_sat_in   = sat_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      chunk_ff    <= chunk_in;
      pmag_ff     <= pmag_in;
      acc_ff      <= acc_in;
      dmag_ff     <= dmag_in;
      dneg_ff     <= dneg_in;
      num_ff      <= num_in;
      qneg_ff     <= qneg_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      ovf_ff      <= ovf_in;
      bit_ff      <= bit_in;
      quo_ff      <= quo_in;
      coef_ff     <= coef_in;
      sat_ff      <= sat_in;
      sing_ff     <= sing_in;
      rsp_coef_ff <= rsp_coef_in;
      rsp_sing_ff <= rsp_sing_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_coef_a    = rsp_coef_ff[0];
   assign rsp_coef_b    = rsp_coef_ff[1];
   assign rsp_singular  = rsp_sing_ff;
   assign rsp_saturated = rsp_sat_ff;

   // The partial remainder stays below the divisor during the steps.
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_STEP) |-> (rem_ff < dmag_ext))
      else $error("partial remainder not below divisor");

   // Division never runs with a zero divisor.
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_CHECK || state_ff == S_DIV_STEP) |-> (dmag_ff != '0))
      else $error("division with zero divisor");

   // The sixth product is followed by the determinant test.
   a_products_then_det: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT && prod_ff == LAST_PROD) |=> (state_ff == S_DET))
      else $error("product sequence did not end in determinant test");

   // A singular result carries zero coefficients and no saturation.
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sing_ff) |->
         (rsp_coef_ff == '0 && !rsp_sat_ff))
      else $error("singular result with nonzero coefficients");

endmodule
